/* rtl/blg_pkg.sv */
package blg_pkg;

  localparam int COORD_W = 7;
  localparam int SHADE_W = 4;
  localparam int ERR_W = 9;

  // Raster size. A 7-bit coordinate stays below twice either size, so one
  // compare and subtract brings it on screen.
  localparam int SCREEN_WIDTH = 128;
  localparam int SCREEN_HEIGHT = 96;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SHADE_W-1:0] shade_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    op_t    operation;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    shade_t line_shade;
  } cmd_word_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    shade_t pixel_shade;
    logic   pixel_valid;
    logic   last_pixel;
  } pix_word_t;

  // Classified word handed from the front part to the back part. On an
  // advance only the operation is meaningful.
  typedef struct packed {
    op_t    operation;
    coord_t cur_x;
    coord_t cur_y;
    coord_t target_x;
    coord_t target_y;
    coord_t delta_x;
    coord_t delta_y;
    logic   step_x_neg;
    logic   step_y_neg;
    err_t   error_init;
    shade_t shade;
  } line_job_t;

  function automatic coord_t wrap_coord(input coord_t c, input int limit);
    coord_t r;
    r = c;
    if (32'(c) >= limit) begin
      r = c - COORD_W'(limit);
    end
    return r;
  endfunction

endpackage

/* rtl/blg_front.sv */
module blg_front (
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  blg_pkg::cmd_word_t  cmd,
  input  logic                queue_full,
  output logic                push,
  output blg_pkg::line_job_t  job
);

  blg_pkg::coord_t dx;
  blg_pkg::coord_t dy;
  logic            x_neg;
  logic            y_neg;

  assign cmd_stall = queue_full;
  assign push = cmd_valid && !queue_full;

  assign x_neg = !(cmd.start_x < cmd.end_x);
  assign y_neg = !(cmd.start_y < cmd.end_y);
  assign dx = x_neg ? (cmd.start_x - cmd.end_x) : (cmd.end_x - cmd.start_x);
  assign dy = y_neg ? (cmd.start_y - cmd.end_y) : (cmd.end_y - cmd.start_y);

  always_comb begin
    job.operation  = cmd.operation;
    job.cur_x      = cmd.start_x;
    job.cur_y      = cmd.start_y;
    job.target_x   = cmd.end_x;
    job.target_y   = cmd.end_y;
    job.delta_x    = dx;
    job.delta_y    = dy;
    job.step_x_neg = x_neg;
    job.step_y_neg = y_neg;
    job.shade      = cmd.line_shade;
    if (dx > dy) begin
      job.error_init = blg_pkg::err_t'({2'b00, dx >> 1});
    end else begin
      job.error_init = -blg_pkg::err_t'({2'b00, dy >> 1});
    end
  end

endmodule

/* rtl/blg_queue.sv */
module blg_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  blg_pkg::line_job_t push_job,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output blg_pkg::line_job_t head_job
);

  localparam int PTR_W = (blg_pkg::QUEUE_DEPTH > 1) ? $clog2(blg_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(blg_pkg::QUEUE_DEPTH + 1);

  blg_pkg::line_job_t slots [blg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full = (count == CNT_W'(blg_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = p + 1'b1;
    if (32'(p) == blg_pkg::QUEUE_DEPTH - 1) begin
      r = '0;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    32'(count) <= blg_pkg::QUEUE_DEPTH)
    else $error("queue count exceeds its depth");

  assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("queue popped while empty");

endmodule

/* rtl/blg_back.sv */
module blg_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  blg_pkg::line_job_t head_job,
  output logic               pop,
  output logic               pix_valid,
  input  logic               pix_stall,
  output blg_pkg::pix_word_t pix
);

  blg_pkg::coord_t cur_x, cur_y, target_x, target_y, delta_x, delta_y;
  blg_pkg::coord_t cur_x_next, cur_y_next, target_x_next, target_y_next;
  blg_pkg::coord_t delta_x_next, delta_y_next;
  logic            step_x_neg, step_y_neg, step_x_neg_next, step_y_neg_next;
  blg_pkg::err_t   error_term, error_term_next;
  blg_pkg::shade_t held_shade, held_shade_next;
  logic            line_active, line_active_next;
  blg_pkg::pix_word_t pix_next;

  blg_pkg::err_t   dx_s, dy_s;
  logic            take_x, take_y, last;

  assign pop = head_valid && (!pix_valid || !pix_stall);

  assign dx_s = blg_pkg::err_t'({2'b00, delta_x});
  assign dy_s = blg_pkg::err_t'({2'b00, delta_y});
  assign take_x = error_term > -dx_s;
  assign take_y = error_term < dy_s;

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    target_x_next    = target_x;
    target_y_next    = target_y;
    delta_x_next     = delta_x;
    delta_y_next     = delta_y;
    step_x_neg_next  = step_x_neg;
    step_y_neg_next  = step_y_neg;
    error_term_next  = error_term;
    held_shade_next  = held_shade;
    line_active_next = line_active;
    last             = 1'b0;
    pix_next         = '0;

    if (head_job.operation == blg_pkg::OP_START) begin
      cur_x_next      = head_job.cur_x;
      cur_y_next      = head_job.cur_y;
      target_x_next   = head_job.target_x;
      target_y_next   = head_job.target_y;
      delta_x_next    = head_job.delta_x;
      delta_y_next    = head_job.delta_y;
      step_x_neg_next = head_job.step_x_neg;
      step_y_neg_next = head_job.step_y_neg;
      error_term_next = head_job.error_init;
      held_shade_next = head_job.shade;
    end else if (line_active) begin
      if (take_x) begin
        cur_x_next = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (take_y) begin
        cur_y_next = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      error_term_next = error_term - (take_x ? dy_s : '0) + (take_y ? dx_s : '0);
    end

    // An advance with no line in progress leaves every field at zero.
    if (head_job.operation == blg_pkg::OP_START || line_active) begin
      last = (cur_x_next == target_x_next) && (cur_y_next == target_y_next);
      line_active_next     = !last;
      pix_next.pixel_x     = blg_pkg::wrap_coord(cur_x_next, blg_pkg::SCREEN_WIDTH);
      pix_next.pixel_y     = blg_pkg::wrap_coord(cur_y_next, blg_pkg::SCREEN_HEIGHT);
      pix_next.pixel_shade = held_shade_next;
      pix_next.pixel_valid = 1'b1;
      pix_next.last_pixel  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
      step_x_neg  <= 1'b0;
      step_y_neg  <= 1'b0;
      error_term  <= '0;
      held_shade  <= '0;
      line_active <= 1'b0;
      pix_valid   <= 1'b0;
    end else begin
      if (pop) begin
        cur_x       <= cur_x_next;
        cur_y       <= cur_y_next;
        target_x    <= target_x_next;
        target_y    <= target_y_next;
        delta_x     <= delta_x_next;
        delta_y     <= delta_y_next;
        step_x_neg  <= step_x_neg_next;
        step_y_neg  <= step_y_neg_next;
        error_term  <= error_term_next;
        held_shade  <= held_shade_next;
        line_active <= line_active_next;
        pix_valid   <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix <= pix_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    line_active |-> !((cur_x == target_x) && (cur_y == target_y)))
    else $error("active line already sits on its end point");

  assert property (@(posedge clk) disable iff (rst)
    (pop && pix_next.last_pixel) |=> !line_active)
    else $error("line still active after its last pixel");

  assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix.pixel_valid) |-> (pix.pixel_x == '0 && pix.pixel_y == '0
      && pix.pixel_shade == '0 && !pix.last_pixel))
    else $error("empty result carries nonzero fields");

endmodule

/* rtl/bresenham_line_generator_unit.sv */
// Bresenham line generator for a 128 by 96 raster. A start word carries both
// end points and a shade and returns the start pixel; each advance word returns
// the next pixel, with last_pixel set on the end point, and an advance with no
// line in progress returns a word with pixel_valid low. Every input word gives
// exactly one pixel word. Throughput is one word per clock while pix_stall is low:
// the back end updates the error term with two compares, a subtract and an add.
// With the queue empty and the output free, a taken word is classified
// combinationally by the front, written into the two-entry queue, and then
// registered as a pixel by the back-end step. The queue lets
// input and output stall independently.
module bresenham_line_generator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  blg_pkg::cmd_word_t cmd,
  output logic               pix_valid,
  input  logic               pix_stall,
  output blg_pkg::pix_word_t pix
);

  logic               push;
  logic               pop;
  logic               queue_full;
  logic               head_valid;
  blg_pkg::line_job_t push_job;
  blg_pkg::line_job_t head_job;

  blg_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  blg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  blg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix        (pix)
  );

endmodule
